// ===== hw/rtl/usph_pkg.sv =====
// Shared types, constants and fixed-point helpers for the UV sphere tessellator.
package usph_pkg;

   localparam int MAX_SEG = 64;
   localparam int SEG_W = 7;
   localparam int IDX_W = 13;

   // result kinds
   localparam logic [1:0] KIND_VERTEX   = 2'd0;
   localparam logic [1:0] KIND_TRIANGLE = 2'd1;
   localparam logic [1:0] KIND_REJECT   = 2'd2;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_RADIUS  = 2'd0;
   localparam logic [1:0] REG_LON_SEG = 2'd1;
   localparam logic [1:0] REG_LAT_SEG = 2'd2;

   localparam logic [31:0] PI_Q30  = 32'd3373259426;
   localparam logic [30:0] Q30_ONE = 31'h4000_0000;

   // pipeline depths
   localparam int LANE_LAT = 18;
   localparam int UV_LAT   = 3;

   // exact reciprocals for 30-bit dividends: m = ceil(2^s / d), s = 30 + clog2(d)
   localparam int SH_72 = 30 + $clog2(72);
   localparam int SH_42 = 30 + $clog2(42);
   localparam int SH_20 = 30 + $clog2(20);
   localparam int SH_6  = 30 + $clog2(6);
   localparam int SH_90 = 30 + $clog2(90);
   localparam int SH_56 = 30 + $clog2(56);
   localparam int SH_30 = 30 + $clog2(30);
   localparam int SH_12 = 30 + $clog2(12);
   localparam int SH_2  = 30 + $clog2(2);
   localparam logic [30:0] M_72 = 31'(((64'd1 << SH_72) + 64'd71) / 64'd72);
   localparam logic [30:0] M_42 = 31'(((64'd1 << SH_42) + 64'd41) / 64'd42);
   localparam logic [30:0] M_20 = 31'(((64'd1 << SH_20) + 64'd19) / 64'd20);
   localparam logic [30:0] M_6  = 31'(((64'd1 << SH_6) + 64'd5) / 64'd6);
   localparam logic [30:0] M_90 = 31'(((64'd1 << SH_90) + 64'd89) / 64'd90);
   localparam logic [30:0] M_56 = 31'(((64'd1 << SH_56) + 64'd55) / 64'd56);
   localparam logic [30:0] M_30 = 31'(((64'd1 << SH_30) + 64'd29) / 64'd30);
   localparam logic [30:0] M_12 = 31'(((64'd1 << SH_12) + 64'd11) / 64'd12);
   localparam logic [30:0] M_2  = 31'(((64'd1 << SH_2) + 64'd1) / 64'd2);

   typedef struct packed {
      logic [SEG_W-1:0] lat;
      logic [SEG_W-1:0] lon;
   } point_type;

   // floor(n / d) through the reciprocal multiply
   function automatic logic [29:0] mul_shift(input logic [29:0] n, input logic [30:0] m,
                                             input int sh);
      logic [60:0] p;
      begin
         p = 61'(n) * 61'(m);
         return 30'(p >> sh);
      end
   endfunction

   // Q30 product, truncated
   function automatic logic [29:0] prod_q30(input logic [29:0] a, input logic [30:0] t);
      logic [60:0] p;
      begin
         p = 61'(a) * 61'(t);
         return p[59:30];
      end
   endfunction

   // v / 2^sh, half away from zero
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int sh);
      logic [63:0] m;
      logic        neg;
      begin
         neg = v[63];
         m = neg ? 64'(-v) : 64'(v);
         m = (m + (64'd1 << (sh - 1))) >> sh;
         return neg ? -signed'(m) : signed'(m);
      end
   endfunction

endpackage

// ===== hw/rtl/usph_div.sv =====
// Pipelined restoring divider, a fixed number of quotient bits per stage.
module usph_div #(
   parameter int DW  = 9,
   parameter int QW  = 30,
   parameter int SPS = 6
) (
   input  logic          clock,
   input  logic          en,
   input  logic [DW-1:0] hi,
   input  logic [QW-1:0] lo,
   input  logic [DW-1:0] den,
   output logic [QW-1:0] quo
);

   localparam int NST = QW / SPS;

   logic [DW-1:0] rem_ff [NST];
   logic [QW-1:0] sh_ff  [NST];
   logic [DW-1:0] den_ff [NST];

   for (genvar g = 0; g < NST; g++) begin : g_st
      logic [DW-1:0] r_src;
      logic [QW-1:0] s_src;
      logic [DW-1:0] d_src;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] sh_in;

      if (g == 0) begin : g_first
         assign r_src = hi;
         assign s_src = lo;
         assign d_src = den;
      end else begin : g_next
         assign r_src = rem_ff[g-1];
         assign s_src = sh_ff[g-1];
         assign d_src = den_ff[g-1];
      end

      // numerator bits leave at the top, quotient bits enter at the bottom
      always_comb begin
         logic [DW:0]   r2;
         logic [DW-1:0] r;
         logic [QW-1:0] s;
         r = r_src;
         s = s_src;
         for (int k = 0; k < SPS; k++) begin
            r2 = {r, s[QW-1]};
            s = {s[QW-2:0], 1'b0};
            if (r2 >= {1'b0, d_src}) begin
               r2 = r2 - {1'b0, d_src};
               s[0] = 1'b1;
            end
            r = r2[DW-1:0];
         end
         rem_in = r;
         sh_in = s;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g] <= rem_in;
            sh_ff[g] <= sh_in;
            den_ff[g] <= d_src;
         end
      end
   end

   assign quo = sh_ff[NST-1];

endmodule

// ===== hw/rtl/usph_sincos.sv =====
// Sine and cosine of 2*pi*num/den: octant reduction, angle divide, Taylor series.
module usph_sincos
   import usph_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic [6:0]         num,
   input  logic [7:0]         den,
   output logic signed [31:0] sin_q,
   output logic signed [31:0] cos_q
);

   // {quadrant, swap}, travels from the first stage to the fix-up
   logic [2:0]  side_ff [17];

   logic [6:0]  r1_ff;
   logic [7:0]  d1_ff;
   logic [2:0]  side_in;
   logic [6:0]  r1_in;

   logic [8:0]  nhi_ff;
   logic [29:0] nlo_ff;
   logic [8:0]  dd_ff;
   logic [38:0] num_pi;
   logic [29:0] quo;

   logic [29:0] x_p1_ff, x_p2_ff, x_p3_ff, x_p4_ff, x_p5_ff, x_p6_ff, x_p7_ff, x_p8_ff;
   logic [29:0] x2_p1_ff, x2_p2_ff, x2_p3_ff, x2_p4_ff, x2_p5_ff, x2_p6_ff, x2_p7_ff;
   logic [29:0] x2_p8_ff;
   logic [30:0] ts_p2_ff, tc_p2_ff, ts_p4_ff, tc_p4_ff, ts_p6_ff, tc_p6_ff;
   logic [30:0] ts_p8_ff, tc_p8_ff;
   logic [29:0] ps_p3_ff, pc_p3_ff, ps_p5_ff, pc_p5_ff, ps_p7_ff, pc_p7_ff;
   logic [29:0] s_p9_ff, pc_p9_ff, s_p10_ff;
   logic [30:0] c_p10_ff;

   logic signed [31:0] sin_ff, cos_ff;
   logic signed [31:0] sq, cq;

   // quadrant and remainder of 4*num/den, then fold to [0, pi/4]
   always_comb begin
      logic [9:0] quarter, d10, r;
      logic [1:0] q;
      logic       swap;
      quarter = {1'b0, num, 2'b00};
      d10 = 10'(den);
      if (quarter >= (d10 << 2)) begin
         q = 2'd0;
         r = quarter - (d10 << 2);
      end else if (quarter >= (d10 + (d10 << 1))) begin
         q = 2'd3;
         r = quarter - (d10 + (d10 << 1));
      end else if (quarter >= (d10 << 1)) begin
         q = 2'd2;
         r = quarter - (d10 << 1);
      end else if (quarter >= d10) begin
         q = 2'd1;
         r = quarter - d10;
      end else begin
         q = 2'd0;
         r = quarter;
      end
      swap = {r, 1'b0} > {1'b0, d10};
      r1_in = swap ? 7'(d10 - r) : r[6:0];
      side_in = {q, swap};
   end

   assign num_pi = 39'(r1_ff) * 39'(PI_Q30);

   usph_div #(.DW(9), .QW(30), .SPS(6)) u_div (
      .clock (clock),
      .en    (en),
      .hi    (nhi_ff),
      .lo    (nlo_ff),
      .den   (dd_ff),
      .quo   (quo)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         r1_ff <= r1_in;
         d1_ff <= den;
         side_ff[0] <= side_in;
         for (int k = 1; k < 17; k++) side_ff[k] <= side_ff[k-1];

         nhi_ff <= num_pi[38:30];
         nlo_ff <= num_pi[29:0];
         dd_ff <= {d1_ff, 1'b0};

         x_p1_ff <= quo;
         x2_p1_ff <= prod_q30(quo, {1'b0, quo});

         x_p2_ff <= x_p1_ff;
         x2_p2_ff <= x2_p1_ff;
         ts_p2_ff <= Q30_ONE - 31'(mul_shift(x2_p1_ff, M_72, SH_72));
         tc_p2_ff <= Q30_ONE - 31'(mul_shift(x2_p1_ff, M_90, SH_90));

         x_p3_ff <= x_p2_ff;
         x2_p3_ff <= x2_p2_ff;
         ps_p3_ff <= prod_q30(x2_p2_ff, ts_p2_ff);
         pc_p3_ff <= prod_q30(x2_p2_ff, tc_p2_ff);

         x_p4_ff <= x_p3_ff;
         x2_p4_ff <= x2_p3_ff;
         ts_p4_ff <= Q30_ONE - 31'(mul_shift(ps_p3_ff, M_42, SH_42));
         tc_p4_ff <= Q30_ONE - 31'(mul_shift(pc_p3_ff, M_56, SH_56));

         x_p5_ff <= x_p4_ff;
         x2_p5_ff <= x2_p4_ff;
         ps_p5_ff <= prod_q30(x2_p4_ff, ts_p4_ff);
         pc_p5_ff <= prod_q30(x2_p4_ff, tc_p4_ff);

         x_p6_ff <= x_p5_ff;
         x2_p6_ff <= x2_p5_ff;
         ts_p6_ff <= Q30_ONE - 31'(mul_shift(ps_p5_ff, M_20, SH_20));
         tc_p6_ff <= Q30_ONE - 31'(mul_shift(pc_p5_ff, M_30, SH_30));

         x_p7_ff <= x_p6_ff;
         x2_p7_ff <= x2_p6_ff;
         ps_p7_ff <= prod_q30(x2_p6_ff, ts_p6_ff);
         pc_p7_ff <= prod_q30(x2_p6_ff, tc_p6_ff);

         x_p8_ff <= x_p7_ff;
         x2_p8_ff <= x2_p7_ff;
         ts_p8_ff <= Q30_ONE - 31'(mul_shift(ps_p7_ff, M_6, SH_6));
         tc_p8_ff <= Q30_ONE - 31'(mul_shift(pc_p7_ff, M_12, SH_12));

         s_p9_ff <= prod_q30(x_p8_ff, ts_p8_ff);
         pc_p9_ff <= prod_q30(x2_p8_ff, tc_p8_ff);

         s_p10_ff <= s_p9_ff;
         c_p10_ff <= Q30_ONE - 31'(mul_shift(pc_p9_ff, M_2, SH_2));

         sin_ff <= sq;
         cos_ff <= cq;
      end
   end

   // undo the fold and place the quadrant
   always_comb begin
      logic signed [31:0] a, b;
      if (side_ff[16][0]) begin
         a = signed'(32'(c_p10_ff));
         b = signed'(32'(s_p10_ff));
      end else begin
         a = signed'(32'(s_p10_ff));
         b = signed'(32'(c_p10_ff));
      end
      case (side_ff[16][2:1])
         2'd0: begin
            sq = a;
            cq = b;
         end
         2'd1: begin
            sq = b;
            cq = -a;
         end
         2'd2: begin
            sq = -a;
            cq = -b;
         end
         default: begin
            sq = -b;
            cq = a;
         end
      endcase
   end

   assign sin_q = sin_ff;
   assign cos_q = cos_ff;

endmodule

// ===== hw/rtl/uv_sphere_tessellator_top.sv =====
// Top level of the UV sphere tessellator: config registers, pipeline, result sequencer.
//
//  channel   ports                            direction   moves
//  req       req_valid/ready, lat/lon index    in          one grid point
//  rsp       rsp_valid/ready, kind + fields    out         vertex, triangle or reject
//  csr       psel/penable/pwrite/paddr/...     in/out      radius and segment counts
//
// A point gives 1 to 3 results: a reject alone, or a vertex plus up to two triangles.
// The single output sequencer sets the rate; the 22-stage math pipeline takes a point
// per cycle unless held: the whole pipeline holds while the output register has results
// not yet taken. Reset (synchronous) clears valid bits and loads radius 1.0, 16 and 8
// segments.
module uv_sphere_tessellator_top
   import usph_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic [6:0]          req_lat_index,
   input  logic [6:0]          req_lon_index,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_kind,
   output logic signed [16:0]  rsp_pos_x,
   output logic signed [16:0]  rsp_pos_y,
   output logic signed [16:0]  rsp_pos_z,
   output logic signed [15:0]  rsp_norm_x,
   output logic signed [15:0]  rsp_norm_y,
   output logic signed [15:0]  rsp_norm_z,
   output logic [16:0]         rsp_tex_u,
   output logic [16:0]         rsp_tex_v,
   output logic [12:0]         rsp_corner_a,
   output logic [12:0]         rsp_corner_b,
   output logic [12:0]         rsp_corner_c,

   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [3:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   localparam int ST_T2   = LANE_LAT + 2;
   localparam int ST_LAST = LANE_LAT + 3;

   // ---------------- configuration ----------------
   logic [15:0] radius_ff;
   logic [6:0]  lon_seg_ff, lat_seg_ff;
   logic [6:0]  ls, ts;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 16'd256;
         lon_seg_ff <= 7'd16;
         lat_seg_ff <= 7'd8;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[3:2])
            REG_RADIUS:  radius_ff <= pwdata[15:0];
            REG_LON_SEG: lon_seg_ff <= pwdata[6:0];
            REG_LAT_SEG: lat_seg_ff <= pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_RADIUS:  prdata = {16'd0, radius_ff};
         REG_LON_SEG: prdata = {25'd0, lon_seg_ff};
         REG_LAT_SEG: prdata = {25'd0, lat_seg_ff};
         default:     prdata = 32'd0;
      endcase
   end
   assign pready = 1'b1;

   assign ls = (lon_seg_ff < 7'd3) ? 7'd3 :
               (lon_seg_ff > 7'(MAX_SEG)) ? 7'(MAX_SEG) : lon_seg_ff;
   assign ts = (lat_seg_ff < 7'd2) ? 7'd2 :
               (lat_seg_ff > 7'(MAX_SEG)) ? 7'(MAX_SEG) : lat_seg_ff;

   // ---------------- pipeline ----------------
   logic adv;
   logic [ST_LAST:0] v_ff;
   point_type pt_ff [ST_LAST+1];
   logic [16:0] u_ff [UV_LAT+1:ST_LAST];
   logic [16:0] w_ff [UV_LAT+1:ST_LAST];

   logic signed [31:0] th_sin, th_cos, ph_sin, ph_cos;
   logic [22:0] nu, nv;
   logic [17:0] u_quo, v_quo;

   assign req_ready = adv;

   usph_sincos u_theta (
      .clock (clock),
      .en    (adv),
      .num   (pt_ff[0].lat),
      .den   ({ts, 1'b0}),
      .sin_q (th_sin),
      .cos_q (th_cos)
   );

   usph_sincos u_phi (
      .clock (clock),
      .en    (adv),
      .num   (pt_ff[0].lon),
      .den   ({1'b0, ls}),
      .sin_q (ph_sin),
      .cos_q (ph_cos)
   );

   // uv = round(index * 65536 / segments)
   assign nu = {pt_ff[0].lon, 16'd0} + 23'(ls >> 1);
   assign nv = {pt_ff[0].lat, 16'd0} + 23'(ts >> 1);

   usph_div #(.DW(7), .QW(18), .SPS(6)) u_udiv (
      .clock (clock),
      .en    (adv),
      .hi    (7'(nu[22:18])),
      .lo    (nu[17:0]),
      .den   (ls),
      .quo   (u_quo)
   );

   usph_div #(.DW(7), .QW(18), .SPS(6)) u_vdiv (
      .clock (clock),
      .en    (adv),
      .hi    (7'(nv[22:18])),
      .lo    (nv[17:0]),
      .den   (ts),
      .quo   (v_quo)
   );

   logic signed [61:0] nx_ff, nz_ff;
   logic signed [31:0] ct1_ff, ct2_ff;
   logic signed [31:0] px_ff, pz_ff;
   logic signed [15:0] nrmx2_ff, nrmy2_ff, nrmz2_ff;
   logic signed [15:0] nrmx3_ff, nrmy3_ff, nrmz3_ff;
   logic signed [47:0] prx_ff, pry_ff, prz_ff;
   logic [12:0]        row0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[ST_LAST-1:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pt_ff[0] <= '{lat: req_lat_index, lon: req_lon_index};
         for (int k = 1; k <= ST_LAST; k++) pt_ff[k] <= pt_ff[k-1];
         u_ff[UV_LAT+1] <= u_quo[16:0];
         w_ff[UV_LAT+1] <= v_quo[16:0];
         for (int k = UV_LAT + 2; k <= ST_LAST; k++) begin
            u_ff[k] <= u_ff[k-1];
            w_ff[k] <= w_ff[k-1];
         end

         // normal products
         nx_ff <= 62'(ph_cos * th_sin);
         nz_ff <= 62'(ph_sin * th_sin);
         ct1_ff <= th_cos;

         // rounding to position scale and Q2.14
         px_ff <= 32'(round_shift(64'(nx_ff), 30));
         pz_ff <= 32'(round_shift(64'(nz_ff), 30));
         nrmx2_ff <= 16'(round_shift(64'(nx_ff), 46));
         nrmz2_ff <= 16'(round_shift(64'(nz_ff), 46));
         nrmy2_ff <= 16'(round_shift(64'(ct1_ff), 16));
         ct2_ff <= ct1_ff;

         // scale by radius
         prx_ff <= 48'(px_ff) * 48'(signed'({1'b0, radius_ff}));
         pry_ff <= 48'(ct2_ff) * 48'(signed'({1'b0, radius_ff}));
         prz_ff <= 48'(pz_ff) * 48'(signed'({1'b0, radius_ff}));
         nrmx3_ff <= nrmx2_ff;
         nrmy3_ff <= nrmy2_ff;
         nrmz3_ff <= nrmz2_ff;
         row0_ff <= 13'(14'(ls + 7'd1) * 14'(pt_ff[ST_T2].lat) + 14'(pt_ff[ST_T2].lon));
      end
   end

   // ---------------- output register and sequencer ----------------
   logic               o_valid_ff, o_rej_ff, o_up_ff, o_dn_ff;
   logic [1:0]         ph_ff;
   logic signed [16:0] o_px_ff, o_py_ff, o_pz_ff;
   logic signed [15:0] o_nx_ff, o_ny_ff, o_nz_ff;
   logic [16:0]        o_u_ff, o_v_ff;
   logic [12:0]        o_row0_ff, o_row1_ff;
   logic [1:0]         cnt;
   logic               last;
   logic               rej_in, cell_in;
   point_type          pl;

   assign pl = pt_ff[ST_LAST];
   assign rej_in = (pl.lat > ts) || (pl.lon > ls);
   assign cell_in = (pl.lat < ts) && (pl.lon < ls);

   assign cnt = o_rej_ff ? 2'd1 : 2'(2'd1 + 2'(o_up_ff) + 2'(o_dn_ff));
   assign last = (ph_ff == 2'(cnt - 2'd1));
   assign adv = !o_valid_ff || (rsp_ready && last);

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
         ph_ff <= 2'd0;
      end else if (adv) begin
         o_valid_ff <= v_ff[ST_LAST];
         ph_ff <= 2'd0;
      end else if (rsp_ready) begin
         ph_ff <= ph_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_rej_ff <= rej_in;
         o_up_ff <= cell_in && (pl.lat != 7'd0);
         o_dn_ff <= cell_in && (pl.lat < 7'(ts - 7'd1));
         o_px_ff <= 17'(round_shift(64'(prx_ff), 30));
         o_py_ff <= 17'(round_shift(64'(pry_ff), 30));
         o_pz_ff <= 17'(round_shift(64'(prz_ff), 30));
         o_nx_ff <= nrmx3_ff;
         o_ny_ff <= nrmy3_ff;
         o_nz_ff <= nrmz3_ff;
         o_u_ff <= u_ff[ST_LAST];
         o_v_ff <= w_ff[ST_LAST];
         o_row0_ff <= row0_ff;
         o_row1_ff <= row0_ff + 13'(ls) + 13'd1;
      end
   end

   always_comb begin
      logic is_vtx, use_up;
      is_vtx = (ph_ff == 2'd0) && !o_rej_ff;
      use_up = (ph_ff == 2'd1) && o_up_ff;
      rsp_pos_x = is_vtx ? o_px_ff : 17'sd0;
      rsp_pos_y = is_vtx ? o_py_ff : 17'sd0;
      rsp_pos_z = is_vtx ? o_pz_ff : 17'sd0;
      rsp_norm_x = is_vtx ? o_nx_ff : 16'sd0;
      rsp_norm_y = is_vtx ? o_ny_ff : 16'sd0;
      rsp_norm_z = is_vtx ? o_nz_ff : 16'sd0;
      rsp_tex_u = is_vtx ? o_u_ff : 17'd0;
      rsp_tex_v = is_vtx ? o_v_ff : 17'd0;
      if (ph_ff == 2'd0) begin
         rsp_kind = o_rej_ff ? KIND_REJECT : KIND_VERTEX;
         rsp_corner_a = 13'd0;
         rsp_corner_b = 13'd0;
         rsp_corner_c = 13'd0;
      end else if (use_up) begin
         rsp_kind = KIND_TRIANGLE;
         rsp_corner_a = o_row0_ff;
         rsp_corner_b = o_row1_ff;
         rsp_corner_c = o_row0_ff + 13'd1;
      end else begin
         rsp_kind = KIND_TRIANGLE;
         rsp_corner_a = o_row0_ff + 13'd1;
         rsp_corner_b = o_row1_ff;
         rsp_corner_c = o_row1_ff + 13'd1;
      end
   end

   assign rsp_valid = o_valid_ff;

   // ---------------- checks ----------------
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      o_valid_ff |-> (ph_ff < cnt))
      else $error("result phase beyond result count");

   a_phase_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !last) |=> (rsp_valid && ph_ff == $past(ph_ff) + 2'd1))
      else $error("non-final transaction did not advance to next result");

   a_tri_after_vtx: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_TRIANGLE) |-> (ph_ff != 2'd0 && !o_rej_ff))
      else $error("triangle without preceding vertex");

endmodule

// ===== tb/sv/uv_sphere_tessellator_top_tb.sv =====
// Self-checking testbench for the UV sphere tessellator top level.
`timescale 1ns / 100ps

module uv_sphere_tessellator_top_tb;
   import usph_pkg::*;

   typedef struct {
      logic [1:0]         kind;
      logic signed [16:0] pos_x, pos_y, pos_z;
      logic signed [15:0] norm_x, norm_y, norm_z;
      logic [16:0]        tex_u, tex_v;
      logic [12:0]        corner_a, corner_b, corner_c;
   } sphere_result_type;

   localparam longint unsigned ONE_Q30 = 64'd1 << 30;
   localparam longint unsigned PI_TURN = 64'd3373259426;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [6:0]  req_lat_index = '0;
   logic [6:0]  req_lon_index = '0;

   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_kind;
   logic signed [16:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [15:0] rsp_norm_x, rsp_norm_y, rsp_norm_z;
   logic [16:0]        rsp_tex_u, rsp_tex_v;
   logic [12:0]        rsp_corner_a, rsp_corner_b, rsp_corner_c;

   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   point_type         pending_points[$];
   sphere_result_type expected_results[$];
   int                mismatch_count = 0;
   bit                steady = 1'b0;
   bit                hold_start = 1'b0;
   int                hold_left = 0;

   logic [15:0] cfg_radius = 16'd256;
   logic [6:0]  cfg_lon_seg = 7'd16;
   logic [6:0]  cfg_lat_seg = 7'd8;

   uv_sphere_tessellator_top u_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned clamp_seg(input logic [6:0] reg_val, input int unsigned lo);
      int unsigned v;
      v = 32'(reg_val);
      if (v < lo) v = lo;
      if (v > MAX_SEG) v = MAX_SEG;
      return v;
   endfunction

   // Q30 sine/cosine of an angle already reduced to [0, pi/4]
   function automatic void taylor_q30(input longint unsigned x,
                                      output longint unsigned s, output longint unsigned c);
      longint unsigned x2, t;
      x2 = (x * x) >> 30;
      t = ONE_Q30 - x2 / 72;
      t = ONE_Q30 - ((x2 * t) >> 30) / 42;
      t = ONE_Q30 - ((x2 * t) >> 30) / 20;
      t = ONE_Q30 - ((x2 * t) >> 30) / 6;
      s = (x * t) >> 30;
      t = ONE_Q30 - x2 / 90;
      t = ONE_Q30 - ((x2 * t) >> 30) / 56;
      t = ONE_Q30 - ((x2 * t) >> 30) / 30;
      t = ONE_Q30 - ((x2 * t) >> 30) / 12;
      t = ONE_Q30 - ((x2 * t) >> 30) / 2;
      c = t;
   endfunction

   // sine/cosine of num/den of a full turn
   function automatic void turn_trig(input int unsigned num, input int unsigned den,
                                     output longint sn, output longint cs);
      longint unsigned quarter, r, ang, sq, cq, tmp;
      int unsigned     quad;
      quarter = longint'(num) * 4;
      quad = 32'((quarter / den) & 3);
      r = quarter % den;
      if (2 * r > den) begin
         r = den - r;
         taylor_q30((r * PI_TURN) / (2 * longint'(den)), cq, sq);
      end else begin
         taylor_q30((r * PI_TURN) / (2 * longint'(den)), sq, cq);
      end
      case (quad)
         0: begin sn = sq;  cs = cq;  end
         1: begin sn = cq;  cs = -longint'(sq); end
         2: begin sn = -longint'(sq); cs = -longint'(cq); end
         default: begin sn = -longint'(cq); cs = sq; end
      endcase
   endfunction

   function automatic longint round_away(input longint v, input int sh);
      longint unsigned m;
      m = (v < 0) ? -v : v;
      m = (m + (64'd1 << (sh - 1))) >> sh;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic sphere_result_type blank_result(input logic [1:0] kind);
      sphere_result_type r;
      r = '{kind: kind, default: '0};
      return r;
   endfunction

   // expected vertex / triangles / reject for one grid point at the current settings
   task automatic tessellate_point(input point_type pt);
      int unsigned       ls, ts, lat, lon, row0, row1;
      longint            st, ct, sp, cp, nx, nz, px, pz;
      sphere_result_type r;
      ls = clamp_seg(cfg_lon_seg, 3);
      ts = clamp_seg(cfg_lat_seg, 2);
      lat = 32'(pt.lat);
      lon = 32'(pt.lon);
      if (lat > ts || lon > ls) begin
         r = blank_result(KIND_REJECT);
         expected_results = {expected_results, r};
         return;
      end
      turn_trig(lat, 2 * ts, st, ct);
      turn_trig(lon, ls, sp, cp);
      nx = cp * st;
      nz = sp * st;
      px = round_away(nx, 30);
      pz = round_away(nz, 30);
      r = blank_result(KIND_VERTEX);
      r.pos_x = 17'(round_away(px * longint'(cfg_radius), 30));
      r.pos_y = 17'(round_away(ct * longint'(cfg_radius), 30));
      r.pos_z = 17'(round_away(pz * longint'(cfg_radius), 30));
      r.norm_x = 16'(round_away(nx, 46));
      r.norm_y = 16'(round_away(ct, 16));
      r.norm_z = 16'(round_away(nz, 46));
      r.tex_u = 17'(((longint'(lon) << 16) + ls / 2) / ls);
      r.tex_v = 17'(((longint'(lat) << 16) + ts / 2) / ts);
      expected_results = {expected_results, r};
      if (lat < ts && lon < ls) begin
         row0 = (ls + 1) * lat + lon;
         row1 = row0 + ls + 1;
         if (lat > 0) begin
            r = blank_result(KIND_TRIANGLE);
            r.corner_a = 13'(row0);
            r.corner_b = 13'(row1);
            r.corner_c = 13'(row0 + 1);
            expected_results = {expected_results, r};
         end
         if (lat < ts - 1) begin
            r = blank_result(KIND_TRIANGLE);
            r.corner_a = 13'(row0 + 1);
            r.corner_b = 13'(row1);
            r.corner_c = 13'(row1 + 1);
            expected_results = {expected_results, r};
         end
      end
   endtask

   task automatic report_mismatch(input string name, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", name, got, want, $realtime);
      mismatch_count++;
   endtask

   // driver
   always @(posedge clock) begin
      logic      next_valid;
      point_type next_pt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         next_pt = '{lat: req_lat_index, lon: req_lon_index};
         if (req_valid && req_ready) begin
            tessellate_point(pending_points.pop_front());
            next_valid = 1'b0;
         end
         if (!next_valid && pending_points.size() > 0 &&
             (steady || $urandom_range(99) >= 28)) begin
            next_valid = 1'b1;
            next_pt = pending_points[0];
         end
         req_valid <= next_valid;
         req_lat_index <= next_pt.lat;
         req_lon_index <= next_pt.lon;
      end
   end

   always @(posedge clock) begin
      if (hold_start) hold_left <= 400;
      else if (hold_left > 0) hold_left <= hold_left - 1;
   end

   // monitor
   always @(posedge clock) begin
      sphere_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected transaction, kind", rsp_kind, -1);
            end else begin
               want = expected_results.pop_front();
               if (rsp_kind !== want.kind) report_mismatch("kind", rsp_kind, want.kind);
               if (rsp_pos_x !== want.pos_x) report_mismatch("pos_x", rsp_pos_x, want.pos_x);
               if (rsp_pos_y !== want.pos_y) report_mismatch("pos_y", rsp_pos_y, want.pos_y);
               if (rsp_pos_z !== want.pos_z) report_mismatch("pos_z", rsp_pos_z, want.pos_z);
               if (rsp_norm_x !== want.norm_x)
                  report_mismatch("norm_x", rsp_norm_x, want.norm_x);
               if (rsp_norm_y !== want.norm_y)
                  report_mismatch("norm_y", rsp_norm_y, want.norm_y);
               if (rsp_norm_z !== want.norm_z)
                  report_mismatch("norm_z", rsp_norm_z, want.norm_z);
               if (rsp_tex_u !== want.tex_u) report_mismatch("tex_u", rsp_tex_u, want.tex_u);
               if (rsp_tex_v !== want.tex_v) report_mismatch("tex_v", rsp_tex_v, want.tex_v);
               if (rsp_corner_a !== want.corner_a)
                  report_mismatch("corner_a", rsp_corner_a, want.corner_a);
               if (rsp_corner_b !== want.corner_b)
                  report_mismatch("corner_b", rsp_corner_b, want.corner_b);
               if (rsp_corner_c !== want.corner_c)
                  report_mismatch("corner_c", rsp_corner_c, want.corner_c);
            end
         end
         rsp_ready <= (hold_left == 0) && !hold_start && (steady || $urandom_range(99) >= 28);
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_RADIUS:  cfg_radius = value[15:0];
         REG_LON_SEG: cfg_lon_seg = value[6:0];
         default:     cfg_lat_seg = value[6:0];
      endcase
   endtask

   task automatic configure(input logic [15:0] rad, input logic [6:0] lon_seg,
                            input logic [6:0] lat_seg);
      csr_write(REG_RADIUS, 32'(rad));
      csr_write(REG_LON_SEG, 32'(lon_seg));
      csr_write(REG_LAT_SEG, 32'(lat_seg));
   endtask

   task automatic drain;
      while (pending_points.size() > 0 || expected_results.size() > 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic queue_point(input int lat, input int lon);
      point_type pt;
      pt = '{lat: 7'(lat), lon: 7'(lon)};
      pending_points = {pending_points, pt};
   endtask

   // mostly in-grid points, some anywhere in the 7-bit range
   task automatic queue_random(input int count);
      int ls, ts;
      ls = clamp_seg(cfg_lon_seg, 3);
      ts = clamp_seg(cfg_lat_seg, 2);
      repeat (count) begin
         if ($urandom_range(99) < 85) queue_point($urandom_range(ts), $urandom_range(ls));
         else queue_point($urandom_range(127), $urandom_range(127));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // default settings: poles, seam, corners, rejects
      queue_point(0, 0);
      queue_point(0, 16);
      queue_point(1, 0);
      queue_point(4, 4);
      queue_point(7, 15);
      queue_point(7, 16);
      queue_point(8, 0);
      queue_point(8, 16);
      queue_point(9, 0);
      queue_point(0, 17);
      queue_point(127, 127);
      queue_point(85, 42);
      drain();

      // zero radius, clamped-low segment counts
      configure(16'd0, 7'd0, 7'd0);
      queue_point(0, 0);
      queue_point(1, 2);
      queue_point(2, 3);
      queue_point(1, 1);
      queue_point(3, 0);
      queue_point(0, 4);
      drain();

      // largest radius, counts clamped high
      configure(16'hFFFF, 7'd127, 7'd127);
      queue_point(0, 0);
      queue_point(32, 16);
      queue_point(63, 63);
      queue_point(64, 64);
      queue_point(65, 0);
      queue_point(0, 65);
      drain();

      // steady traffic with a long receiver stall
      configure(16'd384, 7'd24, 7'd12);
      steady = 1'b1;
      queue_random(60);
      repeat (20) @(posedge clock);
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      drain();
      steady = 1'b0;

      repeat (4) begin
         configure(16'($urandom), 7'($urandom_range(70)), 7'($urandom_range(70)));
         queue_random(32);
         drain();
      end

      configure(16'd256, 7'd3, 7'd2);
      queue_random(10);
      drain();

      if (mismatch_count == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #4ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
